@@ hdl/location_code_decoder_top_assert.svh @@
// Assertion macros shared by the location code decoder modules.
// Each macro expects the including module to have aclk and aresetn in scope.
`ifndef LOCATION_CODE_DECODER_TOP_ASSERT_SVH
`define LOCATION_CODE_DECODER_TOP_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define LCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent, outside reset.
`define LCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lcd_pkg.sv @@
// Package of the location code decoder: constants, queue item and result types,
// character classification and CRC-8 helpers. No dependencies.
`timescale 1ns / 1ps

package lcd_pkg;

    localparam int SEXTET_W       = 6;
    localparam int PAYLOAD_W      = 96;
    localparam int CNT_W          = 5;
    localparam logic [CNT_W-1:0] CODE_LEN     = 5'd16;
    localparam logic [CNT_W-1:0] SPAN_SAT     = 5'd17;
    localparam logic [CNT_W-1:0] CRC_LAST_POS = 5'd14;
    localparam int CRC_PART_BITS  = 4;
    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_FORMAT_VERSION = 1'b0;
    localparam logic REG_ALLOWED_MODES  = 1'b1;
    localparam logic [3:0]  FORMAT_VERSION_RST = 4'd1;
    localparam logic [15:0] ALLOWED_MODES_RST  = 16'd1;

    typedef enum logic [2:0] {
        ERR_OK           = 3'd0,
        ERR_LENGTH       = 3'd1,
        ERR_BAD_CHAR     = 3'd2,
        ERR_VERSION_ZERO = 3'd3,
        ERR_VERSION      = 3'd4,
        ERR_MODE         = 3'd5,
        ERR_CRC          = 3'd6
    } lcd_err_t;

    typedef struct packed {
        logic                last;
        logic                is_space;
        logic                bad;
        logic [SEXTET_W-1:0] val;
    } lcd_item_t;

    typedef struct packed {
        logic        valid_res;
        lcd_err_t    error_code;
        logic [3:0]  mode;
        logic [15:0] zoom_code;
        logic [31:0] center_x_code;
        logic [31:0] center_y_code;
    } lcd_result_t;

    function automatic logic char_is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

    // Returns {in_alphabet, value}; the value is zero outside the alphabet.
    function automatic logic [SEXTET_W:0] char_sextet(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= 8'h41 && c <= 8'h5a) begin
            v = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            v = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30 + 8'd52;
        end else if (c == 8'h2d) begin
            v = 8'd62;
        end else if (c == 8'h5f) begin
            v = 8'd63;
        end else begin
            return '0;
        end
        return {1'b1, v[SEXTET_W-1:0]};
    endfunction

    // One message bit into the CRC, most significant bit first.
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic d);
        logic fb;
        fb = crc[7] ^ d;
        return {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    endfunction

endpackage

@@ hdl/location_code_decoder_top.sv @@
// Top level of the location code decoder: configuration registers on an APB port,
// the front (classify and queue) and the back (decode and check). Depends on lcd_pkg.
//
// Usage: characters of a location code enter on the s_ channel, one per
// transaction, with s_last set on the final character. Leading and trailing
// whitespace is dropped; the trimmed text must hold 16 Base64URL characters.
// For every transaction with s_last set, one result transaction leaves on the
// m_ channel: m_valid_res, m_error_code, m_mode and the raw zoom and coordinate
// codes, which read as zero when the code fails a check.
// Throughput is one character per cycle while the receiver takes results. The last
// character of a code waits in the two-entry queue and is decoded into the output
// register as it leaves; the result then appears on the m_ channel.
// When the receiver stalls, the result waits in the output register while the
// queue keeps taking characters; s_ready falls only once the queue is full.
// Reset clears the queue, the string state and m_valid and sets format_version and
// allowed_modes to 1. The user must write configuration through APB at byte address
// 0 (format_version) and 4 (allowed_modes) only while idle; the block does not check.
`timescale 1ns / 1ps

module location_code_decoder_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_char_code,
    input  logic                           s_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_valid_res,
    output logic [2:0]                     m_error_code,
    output logic [3:0]                     m_mode,
    output logic [15:0]                    m_zoom_code,
    output logic [31:0]                    m_center_x_code,
    output logic [31:0]                    m_center_y_code,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lcd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lcd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lcd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import lcd_pkg::*;

    logic [3:0]  format_version_reg, format_version_next;
    logic [15:0] allowed_modes_reg, allowed_modes_next;
    logic        cfg_write;
    logic        q_valid, q_ready;
    lcd_item_t   q_item;
    lcd_result_t res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        format_version_next = format_version_reg;
        allowed_modes_next  = allowed_modes_reg;
        if (cfg_write) begin
            unique case (paddr[REG_SEL_BIT])
                REG_FORMAT_VERSION: format_version_next = pwdata[3:0];
                REG_ALLOWED_MODES:  allowed_modes_next  = pwdata[15:0];
                default: ;
            endcase
        end
        unique case (paddr[REG_SEL_BIT])
            REG_FORMAT_VERSION: prdata = {{(APB_DATA_W - 4){1'b0}}, format_version_reg};
            REG_ALLOWED_MODES:  prdata = {{(APB_DATA_W - 16){1'b0}}, allowed_modes_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_version_reg <= FORMAT_VERSION_RST;
            allowed_modes_reg  <= ALLOWED_MODES_RST;
        end else begin
            format_version_reg <= format_version_next;
            allowed_modes_reg  <= allowed_modes_next;
        end
    end

    lcd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_last      (s_last),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    lcd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item),
        .format_version (format_version_reg),
        .allowed_modes  (allowed_modes_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .res            (res)
    );

    assign m_valid_res     = res.valid_res;
    assign m_error_code    = res.error_code;
    assign m_mode          = res.mode;
    assign m_zoom_code     = res.zoom_code;
    assign m_center_x_code = res.center_x_code;
    assign m_center_y_code = res.center_y_code;

endmodule

@@ hdl/lcd_front.sv @@
// Front part of the location code decoder: takes characters, classifies them
// and holds them in a short queue for the back part. Depends on lcd_pkg.
`timescale 1ns / 1ps
`include "location_code_decoder_top_assert.svh"

module lcd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_char_code,
    input  logic              s_last,
    output logic              q_valid,
    input  logic              q_ready,
    output lcd_pkg::lcd_item_t q_item
);
    import lcd_pkg::*;

    lcd_item_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    lcd_item_t          in_item;
    logic [SEXTET_W:0]  sx;
    logic               push, pop;

    always_comb begin
        sx               = char_sextet(s_char_code);
        in_item.last     = s_last;
        in_item.is_space = char_is_space(s_char_code);
        in_item.bad      = !sx[SEXTET_W];
        in_item.val      = sx[SEXTET_W-1:0];
    end

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    `LCD_ASSERT(a_count_bound, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
    `LCD_ASSERT(a_push_room, push |-> count_reg != QCNT_W'(QUEUE_DEPTH), "push into full queue")
    `LCD_ASSERT_NEXT(a_pop_count, pop && !push, count_reg == $past(count_reg) - 1'b1,
        "queue count did not drop on pop")

endmodule

@@ hdl/lcd_back.sv @@
// Back part of the location code decoder: tracks trimming, assembles the payload,
// runs the CRC and registers the result on the last character. Depends on lcd_pkg.
`timescale 1ns / 1ps
`include "location_code_decoder_top_assert.svh"

module lcd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  lcd_pkg::lcd_item_t  q_item,
    input  logic [3:0]          format_version,
    input  logic [15:0]         allowed_modes,
    output logic                m_valid,
    input  logic                m_ready,
    output lcd_pkg::lcd_result_t res
);
    import lcd_pkg::*;

    logic                 started_reg, started_next;
    logic [CNT_W-1:0]     span_count_reg, span_count_next;
    logic [CNT_W-1:0]     trimmed_reg, trimmed_next;
    logic                 gap_reg, gap_next;
    logic                 bad_reg, bad_next;
    logic [7:0]           crc_reg, crc_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic                 m_valid_reg, m_valid_next;
    lcd_result_t          res_reg, res_next;
    logic [CNT_W-1:0]     pos;
    logic                 pop;

    assign q_ready = !m_valid_reg || m_ready;
    assign pop     = q_valid && q_ready;
    assign m_valid = m_valid_reg;
    assign res     = res_reg;
    assign pos     = started_reg ? span_count_reg : '0;

    always_comb begin
        started_next    = started_reg;
        span_count_next = span_count_reg;
        trimmed_next    = trimmed_reg;
        gap_next        = gap_reg;
        bad_next        = bad_reg;
        crc_next        = crc_reg;
        payload_next    = payload_reg;
        if (pop) begin
            if (q_item.is_space) begin
                if (started_reg) begin
                    gap_next = 1'b1;
                    if (span_count_reg < SPAN_SAT) begin
                        span_count_next = span_count_reg + 1'b1;
                    end
                end
            end else begin
                started_next    = 1'b1;
                bad_next        = bad_reg || gap_reg || q_item.bad;
                span_count_next = (pos < SPAN_SAT) ? pos + 1'b1 : pos;
                trimmed_next    = span_count_next;
                if (pos < CODE_LEN) begin
                    payload_next = {payload_reg[PAYLOAD_W-SEXTET_W-1:0], q_item.val};
                end
                for (int k = 0; k < SEXTET_W; k++) begin
                    if (pos < CRC_LAST_POS || (pos == CRC_LAST_POS && k < CRC_PART_BITS)) begin
                        crc_next = crc_step(crc_next, q_item.val[SEXTET_W-1-k]);
                    end
                end
            end
        end
    end

    always_comb begin
        lcd_err_t err;
        logic [3:0] version;
        logic [3:0] mode;
        version = payload_next[95:92];
        mode    = payload_next[91:88];
        if (trimmed_next != CODE_LEN) begin
            err = ERR_LENGTH;
        end else if (bad_next) begin
            err = ERR_BAD_CHAR;
        end else if (version == 4'd0) begin
            err = ERR_VERSION_ZERO;
        end else if (version != format_version) begin
            err = ERR_VERSION;
        end else if (!allowed_modes[mode]) begin
            err = ERR_MODE;
        end else if (crc_next != payload_next[7:0]) begin
            err = ERR_CRC;
        end else begin
            err = ERR_OK;
        end
        res_next            = '0;
        res_next.error_code = err;
        if (err == ERR_OK) begin
            res_next.valid_res     = 1'b1;
            res_next.mode          = mode;
            res_next.zoom_code     = payload_next[87:72];
            res_next.center_x_code = payload_next[71:40];
            res_next.center_y_code = payload_next[39:8];
        end
        m_valid_next = m_valid_reg && !m_ready;
        if (pop && q_item.last) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg    <= 1'b0;
            span_count_reg <= '0;
            trimmed_reg    <= '0;
            gap_reg        <= 1'b0;
            bad_reg        <= 1'b0;
            crc_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop && q_item.last) begin
                started_reg    <= 1'b0;
                span_count_reg <= '0;
                trimmed_reg    <= '0;
                gap_reg        <= 1'b0;
                bad_reg        <= 1'b0;
                crc_reg        <= '0;
            end else begin
                started_reg    <= started_next;
                span_count_reg <= span_count_next;
                trimmed_reg    <= trimmed_next;
                gap_reg        <= gap_next;
                bad_reg        <= bad_next;
                crc_reg        <= crc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        payload_reg <= payload_next;
        if (pop && q_item.last) begin
            res_reg <= res_next;
        end
    end

    `LCD_ASSERT(a_span_bound, span_count_reg <= SPAN_SAT, "span count past saturation")
    `LCD_ASSERT(a_valid_ok, m_valid_reg && res_reg.valid_res |-> res_reg.error_code == ERR_OK,
        "valid result with an error code")
    `LCD_ASSERT(a_fail_zero, m_valid_reg && !res_reg.valid_res |-> res_reg.mode == '0 &&
        res_reg.zoom_code == '0 && res_reg.center_x_code == '0 && res_reg.center_y_code == '0,
        "failed result carries payload")
    `LCD_ASSERT_NEXT(a_string_clear, pop && q_item.last,
        !started_reg && span_count_reg == '0 && crc_reg == '0 && !bad_reg,
        "string state not cleared after last character")

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench of the location code decoder: drives characters, APB register
// writes and result back-pressure, and compares every result with its own decoder model.
// Depends on lcd_pkg and location_code_decoder_top.
`timescale 1ns / 1ps

import lcd_pkg::*;

function automatic logic is_ws_code(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
endfunction

function automatic int b64_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "-") return 62;
    if (c == "_") return 63;
    return -1;
endfunction

function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < 26) return 8'("A") + 8'(v);
    if (v < 52) return 8'("a") + 8'(v) - 8'd26;
    if (v < 62) return 8'("0") + 8'(v) - 8'd52;
    if (v == 62) return 8'("-");
    return 8'("_");
endfunction

function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int k = 0; k < 8; k++) begin
        r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    end
    return r;
endfunction

class lcd_scoreboard;
    logic [3:0]  cfg_version;
    logic [15:0] cfg_modes;
    logic        in_code;
    logic        ws_after_start;
    logic        bad_seen;
    logic [4:0]  span_len;
    logic [4:0]  text_len;
    logic [17:0] sextet_acc;
    logic [7:0]  bytes [12];
    logic [7:0]  crc_acc;
    lcd_result_t pending_q[$];
    int unsigned mismatches;

    function new();
        cfg_version = FORMAT_VERSION_RST;
        cfg_modes   = ALLOWED_MODES_RST;
        mismatches  = 0;
        foreach (bytes[i]) bytes[i] = 8'h00;
        clear_text();
    endfunction

    function void clear_text();
        in_code        = 1'b0;
        ws_after_start = 1'b0;
        bad_seen       = 1'b0;
        span_len       = '0;
        text_len       = '0;
        sextet_acc     = '0;
        crc_acc        = 8'h00;
    endfunction

    function void write_reg(input logic idx, input logic [31:0] value);
        if (idx == REG_FORMAT_VERSION) begin
            cfg_version = value[3:0];
        end else begin
            cfg_modes = value[15:0];
        end
    endfunction

    function void note_char(input logic [7:0] c, input logic is_last);
        int          v;
        int          base;
        logic [4:0]  pos;
        logic [23:0] bits;
        logic [3:0]  ver;
        logic [3:0]  md;
        lcd_err_t    err;
        lcd_result_t r;
        if (is_ws_code(c)) begin
            if (in_code) begin
                ws_after_start = 1'b1;
                if (span_len < SPAN_SAT) span_len = span_len + 5'd1;
            end
        end else begin
            if (!in_code) begin
                in_code  = 1'b1;
                span_len = '0;
            end
            if (ws_after_start) bad_seen = 1'b1;
            pos = span_len;
            if (span_len < SPAN_SAT) span_len = span_len + 5'd1;
            text_len = span_len;
            v = b64_value(c);
            if (v < 0) begin
                bad_seen = 1'b1;
                v = 0;
            end
            if (pos < CODE_LEN) begin
                if (pos[1:0] == 2'd0) begin
                    sextet_acc = 18'(v);
                end else if (pos[1:0] != 2'd3) begin
                    sextet_acc = {sextet_acc[11:0], 6'(v)};
                end else begin
                    bits = {sextet_acc, 6'(v)};
                    base = int'(pos[3:2]) * 3;
                    bytes[base]     = bits[23:16];
                    bytes[base + 1] = bits[15:8];
                    bytes[base + 2] = bits[7:0];
                    for (int i = base; i < base + 3; i++) begin
                        if (i < 11) crc_acc = crc8_update(crc_acc, bytes[i]);
                    end
                    sextet_acc = '0;
                end
            end
        end
        if (is_last) begin
            ver = bytes[0][7:4];
            md  = bytes[0][3:0];
            if (text_len != CODE_LEN) err = ERR_LENGTH;
            else if (bad_seen) err = ERR_BAD_CHAR;
            else if (ver == 4'd0) err = ERR_VERSION_ZERO;
            else if (ver != cfg_version) err = ERR_VERSION;
            else if (!cfg_modes[md]) err = ERR_MODE;
            else if (crc_acc != bytes[11]) err = ERR_CRC;
            else err = ERR_OK;
            r = '0;
            r.error_code = err;
            r.valid_res  = (err == ERR_OK);
            if (err == ERR_OK) begin
                r.mode          = md;
                r.zoom_code     = {bytes[1], bytes[2]};
                r.center_x_code = {bytes[3], bytes[4], bytes[5], bytes[6]};
                r.center_y_code = {bytes[7], bytes[8], bytes[9], bytes[10]};
            end
            pending_q = {pending_q, r};
            clear_text();
        end
    endfunction

    function void check_result(input lcd_result_t got);
        lcd_result_t want;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: unexpected result valid=%0d err=%0d mode=%h zoom=%h x=%h y=%h",
                         $realtime, got.valid_res, got.error_code, got.mode, got.zoom_code,
                         got.center_x_code, got.center_y_code);
            end
            return;
        end
        want = pending_q.pop_front();
        if (got.valid_res !== want.valid_res || got.error_code !== want.error_code ||
            got.mode !== want.mode || got.zoom_code !== want.zoom_code ||
            got.center_x_code !== want.center_x_code ||
            got.center_y_code !== want.center_y_code) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: mismatch expected valid=%0d err=%0d mode=%h zoom=%h x=%h y=%h",
                         $realtime, want.valid_res, want.error_code, want.mode,
                         want.zoom_code, want.center_x_code, want.center_y_code);
                $display("%0t:          actual   valid=%0d err=%0d mode=%h zoom=%h x=%h y=%h",
                         $realtime, got.valid_res, got.error_code, got.mode,
                         got.zoom_code, got.center_x_code, got.center_y_code);
            end
        end
    endfunction
endclass

module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 104;

    typedef enum int {
        TXT_GOOD,
        TXT_BAD_CRC,
        TXT_ANY_VERSION,
        TXT_ANY_MODE,
        TXT_INNER_SPACE,
        TXT_BAD_CHAR,
        TXT_BAD_LENGTH,
        TXT_NOISE
    } text_kind_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_char_code = 8'h00;
    logic                  s_last      = 1'b0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic                  m_valid_res;
    logic [2:0]            m_error_code;
    logic [3:0]            m_mode;
    logic [15:0]           m_zoom_code;
    logic [31:0]           m_center_x_code;
    logic [31:0]           m_center_y_code;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          items_sent     = 0;
    int          quiet_cycles   = 0;
    logic [7:0]  text_q[$];
    lcd_scoreboard sb = new();

    location_code_decoder_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_valid_res     (m_valid_res),
        .m_error_code    (m_error_code),
        .m_mode          (m_mode),
        .m_zoom_code     (m_zoom_code),
        .m_center_x_code (m_center_x_code),
        .m_center_y_code (m_center_y_code),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : monitor
        lcd_result_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_char(s_char_code, s_last);
            end
            if (m_valid && m_ready) begin
                got.valid_res     = m_valid_res;
                got.error_code    = lcd_err_t'(m_error_code);
                got.mode          = m_mode;
                got.zoom_code     = m_zoom_code;
                got.center_x_code = m_center_x_code;
                got.center_y_code = m_center_y_code;
                sb.check_result(got);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("location_code_decoder_top test failed");
                $finish;
            end
        end
    end

    function automatic void add_char(input logic [7:0] c);
        text_q = {text_q, c};
    endfunction

    task automatic send_char(input logic [7:0] c, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        s_last      <= is_last;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_text();
        foreach (text_q[i]) begin
            send_char(text_q[i], i == text_q.size() - 1);
        end
        items_sent += text_q.size();
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] value);
        logic [APB_ADDR_W-1:0] addr;
        addr = '0;
        addr[REG_SEL_BIT] = idx;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] random_ws();
        int k;
        k = $urandom_range(5);
        return (k == 5) ? 8'h20 : 8'h09 + 8'(k);
    endfunction

    function automatic logic [7:0] random_bad_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (b64_value(c) >= 0 || is_ws_code(c));
        return c;
    endfunction

    // Appends the 16 characters of a payload with the given header and a correct CRC.
    task automatic encode_payload(input logic [3:0] ver, input logic [3:0] md,
                                  input int fill);
        logic [7:0]  pay [12];
        logic [23:0] bits;
        pay[0] = {ver, md};
        for (int i = 1; i < 11; i++) begin
            pay[i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hff : 8'($urandom_range(255));
        end
        pay[11] = 8'h00;
        for (int i = 0; i < 11; i++) pay[11] = crc8_update(pay[11], pay[i]);
        for (int g = 0; g < 4; g++) begin
            bits = {pay[3*g], pay[3*g + 1], pay[3*g + 2]};
            add_char(b64_char(bits[23:18]));
            add_char(b64_char(bits[17:12]));
            add_char(b64_char(bits[11:6]));
            add_char(b64_char(bits[5:0]));
        end
    endtask

    task automatic build_random_text();
        int         r;
        text_kind_t kind;
        logic [3:0] ver;
        logic [3:0] md;
        logic [5:0] bits;
        text_q.delete();
        r = $urandom_range(99);
        kind = (r < 55) ? TXT_GOOD : (r < 63) ? TXT_BAD_CRC : (r < 71) ? TXT_ANY_VERSION :
               (r < 77) ? TXT_ANY_MODE : (r < 83) ? TXT_INNER_SPACE :
               (r < 89) ? TXT_BAD_CHAR : (r < 94) ? TXT_BAD_LENGTH : TXT_NOISE;
        if (kind == TXT_NOISE) begin
            repeat ($urandom_range(20, 1)) add_char(8'($urandom_range(255)));
            return;
        end
        ver = (kind == TXT_ANY_VERSION) ? 4'($urandom_range(15)) : sb.cfg_version;
        md  = 4'($urandom_range(15));
        if (kind != TXT_ANY_MODE && sb.cfg_modes != 16'h0000) begin
            while (!sb.cfg_modes[md]) md = 4'($urandom_range(15));
        end
        encode_payload(ver, md, $urandom_range(9));
        if (kind == TXT_BAD_CRC) begin
            // Change the last character: the final six bits hold the low end of the CRC.
            bits = 6'(b64_value(text_q[15])) ^ 6'($urandom_range(63, 1));
            text_q[15] = b64_char(bits);
        end
        if (kind == TXT_INNER_SPACE) text_q[$urandom_range(14, 1)] = random_ws();
        if (kind == TXT_BAD_CHAR) text_q[$urandom_range(15)] = random_bad_char();
        if (kind == TXT_BAD_LENGTH) begin
            if ($urandom_range(1) == 0) begin
                repeat ($urandom_range(16, 1)) void'(text_q.pop_back());
            end else begin
                repeat ($urandom_range(6, 1)) add_char(b64_char(6'($urandom_range(63))));
            end
        end
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(3, 1)) text_q.push_front(random_ws());
        end
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(3, 1)) add_char(random_ws());
        end
        if (text_q.size() == 0) add_char(random_ws());
    endtask

    initial begin
        int         sub;
        logic [3:0] ver;
        logic [15:0] modes;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        text_q.delete();
        encode_payload(4'd1, 4'd0, 1);
        text_q.push_front(8'h20);
        add_char(8'h0d);
        send_text();
        text_q.delete();
        add_char(8'h00);
        send_text();
        text_q.delete();
        add_char(8'hff);
        send_text();
        text_q.delete();
        add_char(8'h20);
        send_text();
        text_q.delete();
        add_char(8'h5f);
        send_text();
        text_q.delete();
        add_char(8'h2d);
        send_text();
        wait_drain();

        for (sub = 0; sub < 8; sub++) begin
            case (sub / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            case (sub)
                0: begin ver = 4'd15; modes = 16'hffff; end
                1: begin ver = 4'd1;  modes = 16'h0001; end
                2: begin ver = 4'd15; modes = 16'h0000; end
                3: begin ver = 4'd1;  modes = 16'h8000; end
                default: begin
                    ver   = 4'($urandom_range(15, 1));
                    modes = 16'($urandom_range(65535));
                end
            endcase
            apb_write(REG_FORMAT_VERSION, ($urandom() & ~32'hf) | 32'(ver));
            apb_write(REG_ALLOWED_MODES, ($urandom() & ~32'hffff) | 32'(modes));
            @(posedge aclk);
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) begin
                build_random_text();
                send_text();
            end
            wait_drain();
        end

        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("location_code_decoder_top test passed");
        end else begin
            $display("location_code_decoder_top test failed");
        end
        $finish;
    end

endmodule
